// ----- design/rll_pkg.sv -----
// rll_pkg: shared types and constants for the reservation lease lock
// used by rll_step and reservation_lease_lock_core, no dependencies
package rll_pkg;

  typedef enum logic [1:0] {
    CMD_OTHER   = 2'd0,
    CMD_RESERVE = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_REFUSED      = 2'd1,
    ST_NOT_EXECUTED = 2'd2
  } status_e;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned IdW      = 32;
  localparam int unsigned LeaseW   = 16;
  localparam int unsigned MaxLeaseW = 31;

  localparam logic [MaxLeaseW-1:0] MaxLeaseReset = 31'd65535;

  typedef struct packed {
    logic [1:0]        command;
    logic              overwrite;
    logic [LeaseW-1:0] lease_time;
    logic [IdW-1:0]    requester_id;
    logic [TimeW-1:0]  current_time;
  } req_t;

  typedef struct packed {
    logic [1:0]     status;
    logic [IdW-1:0] owner_id;
    logic           reserved_flag;
    logic           restart_request;
  } rsp_t;

  typedef struct packed {
    logic [IdW-1:0]    owner;
    logic [LeaseW-1:0] lease_length;
    logic [TimeW-1:0]  lease_start;
    logic              reserved_bit;
  } lock_state_t;

endpackage

// ----- design/rll_step.sv -----
// rll_step: expiry check and command decode for one lock item
// depends on rll_pkg
module rll_step (
  input  rll_pkg::lock_state_t               state_i,
  input  rll_pkg::req_t                      req_i,
  input  logic [rll_pkg::MaxLeaseW-1:0]      max_lease_i,
  output rll_pkg::lock_state_t               state_o,
  output rll_pkg::rsp_t                      rsp_o
);

  logic [rll_pkg::TimeW-1:0] elapsed;
  logic                      expired;
  rll_pkg::lock_state_t      live;
  logic                      may_act;
  rll_pkg::lock_state_t      nxt;
  rll_pkg::status_e          status;
  logic                      restart;

  // negative elapsed time never expires the lease
  assign elapsed = req_i.current_time - state_i.lease_start;
  assign expired = (state_i.owner != '0) && !elapsed[rll_pkg::TimeW-1] &&
                   ((elapsed > {{(rll_pkg::TimeW-rll_pkg::LeaseW){1'b0}},
                                state_i.lease_length}) ||
                    (elapsed[rll_pkg::MaxLeaseW-1:0] > max_lease_i));

  always_comb begin
    live = state_i;
    if (expired) begin
      live.owner        = '0;
      live.lease_length = '0;
    end
  end

  assign may_act = (live.owner == '0) || (live.owner == req_i.requester_id);

  always_comb begin
    nxt     = live;
    status  = rll_pkg::ST_NOT_EXECUTED;
    restart = 1'b0;
    unique case (rll_pkg::cmd_e'(req_i.command)) inside
      rll_pkg::CMD_RESERVE: begin
        if (req_i.overwrite || may_act) begin
          nxt.owner        = req_i.requester_id;
          nxt.lease_length = req_i.lease_time;
          if (req_i.requester_id != '0) begin
            nxt.lease_start = req_i.current_time;
          end
          nxt.reserved_bit = 1'b1;
          status           = rll_pkg::ST_OK;
        end else begin
          status = rll_pkg::ST_REFUSED;
        end
      end
      rll_pkg::CMD_RELEASE, rll_pkg::CMD_RESTART: begin
        restart = (rll_pkg::cmd_e'(req_i.command) == rll_pkg::CMD_RESTART);
        if (may_act) begin
          nxt.owner        = '0;
          nxt.lease_length = '0;
          nxt.reserved_bit = 1'b0;
          status           = rll_pkg::ST_OK;
        end else begin
          status = rll_pkg::ST_REFUSED;
        end
      end
      default: begin
        status = rll_pkg::ST_NOT_EXECUTED;
      end
    endcase
  end

  assign state_o               = nxt;
  assign rsp_o.status          = status;
  assign rsp_o.owner_id        = nxt.owner;
  assign rsp_o.reserved_flag   = nxt.reserved_bit;
  assign rsp_o.restart_request = restart;

endmodule

// ----- design/reservation_lease_lock_core.sv -----
// reservation_lease_lock_core: top level of the single-owner lease lock
// depends on rll_pkg and rll_step
//
// single-owner lease lock with timeout. each request item is captured in an
// input register, then one pass of short logic (a 32-bit time subtract, two
// compares and the command decode in rll_step) updates the lock state and
// loads the result register. one item is accepted per cycle for as long as
// results are taken; the output register lets a new item enter while a
// finished result still waits. expiry happens at the start of each item: an
// owned lease is dropped once the signed elapsed time exceeds the lease
// length or max_lease, while the reserved status bit stays set. max_lease
// is written through cfg_we_i / cfg_wdata_i and resets to 65535; the user
// must write it only while no item is in flight, which the block itself
// does not enforce.
module reservation_lease_lock_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rll_pkg::MaxLeaseW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rll_pkg::req_t                 in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rll_pkg::rsp_t                 out_item_o
);

  // configuration register
  logic [rll_pkg::MaxLeaseW-1:0] max_lease_q;

  // input stage
  logic          s1_valid_q;
  rll_pkg::req_t s1_item_q;
  logic          s1_adv;

  // lock state, updated as an item moves into the result register
  rll_pkg::lock_state_t state_q;
  rll_pkg::lock_state_t state_d;

  // result register
  logic          out_valid_q;
  rll_pkg::rsp_t out_item_q;
  rll_pkg::rsp_t rsp_d;

  // the result slot is free when empty or being taken this cycle
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  rll_step u_step (
    .state_i     (state_q),
    .req_i       (s1_item_q),
    .max_lease_i (max_lease_q),
    .state_o     (state_d),
    .rsp_o       (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_lease_q <= rll_pkg::MaxLeaseReset;
    end else if (cfg_we_i) begin
      max_lease_q <= cfg_wdata_i;
    end
  end

  // input register: valid cleared on reset, payload loads on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item_i;
    end
  end

  // lock state commits exactly once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_item_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTH
  // back-pressure only when both stages are occupied
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled while a stage is free");

  // lock state moves only when an item is processed
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(state_q))
    else $error("lock state changed without an item");

  // a successful restart leaves the lock free and unreserved
  a_restart_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.restart_request &&
     (out_item_o.status == rll_pkg::ST_OK)) |->
    ((out_item_o.owner_id == '0) && !out_item_o.reserved_flag))
    else $error("restart did not free the lock");

  // a command that is not executed never raises restart
  a_noexec_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status == rll_pkg::ST_NOT_EXECUTED)) |->
    !out_item_o.restart_request)
    else $error("restart raised on a command that was not executed");
`endif

endmodule
